FILE: rtl/bitmap_page_allocator_top_macros.svh
// Assertion macros shared by the page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// Types, constants and helper functions of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int unsigned NUM_PAGES      = 65536;
  localparam int unsigned RESERVED_PAGES = 512;
  localparam logic [31:0] MAP_BASE       = 32'h0020_0000;
  localparam int unsigned FRAME_SHIFT    = 12;

  localparam int unsigned RES_LIMIT  = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
  localparam int unsigned MAP_WORDS  = (NUM_PAGES + 31) / 32;
  localparam int unsigned GROUPS_RAW = (MAP_WORDS + 31) / 32;
  // at least two groups so that group indices are never zero bits wide
  localparam int unsigned GROUPS     = (GROUPS_RAW < 2) ? 2 : GROUPS_RAW;
  localparam int unsigned GRP_W      = $clog2(GROUPS);
  localparam int unsigned WORD_W     = GRP_W + 5;
  localparam int unsigned PAGE_W     = WORD_W + 5;
  localparam int unsigned MAP_DEPTH  = GROUPS * 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] page_address;
    status_t     status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_GRP,
    S_A_SUM,
    S_A_WORD,
    S_F_WORD,
    S_SWEEP,
    S_RESP
  } state_t;

  // index of the lowest clear bit; isolate it, then encode the one-hot
  function automatic logic [4:0] ffz32(input logic [31:0] x);
    logic [31:0] y;
    logic [31:0] iso;
    logic [4:0]  idx;
    y   = ~x;
    iso = y & (~y + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) idx = idx | 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [GRP_W-1:0] ffz_grp(input logic [GROUPS-1:0] x);
    logic [GROUPS-1:0] y;
    logic [GROUPS-1:0] iso;
    logic [GRP_W-1:0]  idx;
    y   = ~x;
    iso = y & (~y + GROUPS'(1));
    idx = '0;
    for (int i = 0; i < GROUPS; i++) begin
      if (iso[i]) idx = idx | GRP_W'(i);
    end
    return idx;
  endfunction

  // map word after reset: reserved pages set
  function automatic logic [31:0] reset_word(input logic [WORD_W-1:0] w);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 32; b++) begin
      v[b] = ((32'(w) << 5) + 32'(b)) < RES_LIMIT;
    end
    return v;
  endfunction

  // summary entry after reset: bit set where the word is entirely reserved
  function automatic logic [31:0] reset_sum(input logic [GRP_W-1:0] g);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 32; b++) begin
      v[b] = (((32'(g) << 5) + 32'(b) + 32'd1) << 5) <= RES_LIMIT;
    end
    return v;
  endfunction

  function automatic logic [GROUPS-1:0] reset_grp();
    logic [GROUPS-1:0] v;
    v = '0;
    for (int g = 0; g < GROUPS; g++) begin
      v[g] = ((32'(g) + 32'd1) << 10) <= RES_LIMIT;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bitmap_page_allocator_top.sv
// Bitmap first-fit page allocator: sequencer, used-bit map and full-word summary.
`default_nettype none
`include "bitmap_page_allocator_top_macros.svh"

// First-fit physical page allocator, one used bit per page, one item at a time.
// The used map lives in a memory of 32-bit words with one read and one write
// port; a second memory keeps one "word full" bit per map word, and a flip-flop
// vector marks groups of 32 words that are completely full. An allocate walks
// the three levels (group vector, summary entry, map word), each read
// registered, and updates them on the way back; the result then goes through
// the response state into the output register before the next item is taken.
// A free reads the map word and summary entry together and clears both; its
// result then goes through the response state. A free out of range, or the
// unused opcode, goes straight to the response state.
// An init item, and reset, sweep the map one word per cycle, writing the
// reserved-page pattern; in_stall is high throughout.
// The result sits in an output register, so the next item is accepted while
// an earlier result is still stalled downstream; that next item then waits in
// its final state, with in_stall high, until the output register frees.
module bitmap_page_allocator_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire bpa_pkg::in_item_t in_item,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      bpa_pkg::out_item_t out_item
);

  localparam int unsigned GRP_W  = bpa_pkg::GRP_W;
  localparam int unsigned WORD_W = bpa_pkg::WORD_W;
  localparam int unsigned PAGE_W = bpa_pkg::PAGE_W;
  localparam int unsigned GROUPS = bpa_pkg::GROUPS;

  bpa_pkg::state_t    state_r, state_nxt;
  logic [GRP_W-1:0]   grp_idx_r, grp_idx_nxt;
  logic [WORD_W-1:0]  word_idx_r, word_idx_nxt;
  logic [4:0]         bit_r, bit_nxt;
  logic [WORD_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic               sweep_reply_r, sweep_reply_nxt;
  logic [GROUPS-1:0]  grp_full_r, grp_full_nxt;
  bpa_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  bpa_pkg::out_item_t out_item_r, out_item_nxt;

  // used map and summary memories
  logic [31:0]        map_mem [bpa_pkg::MAP_DEPTH];
  logic [31:0]        sum_mem [GROUPS];
  logic [31:0]        map_q_r;
  logic [31:0]        sum_q_r;
  logic               map_we;
  logic [WORD_W-1:0]  map_waddr;
  logic [31:0]        map_wdata;
  logic               sum_we;
  logic [GRP_W-1:0]   sum_waddr;
  logic [31:0]        sum_wdata;

  // decode helpers
  logic [31:0]        free_off;
  logic [19:0]        free_page;
  logic [4:0]         a_bit;
  logic [PAGE_W-1:0]  a_page;
  logic [31:0]        a_word;
  logic [31:0]        a_sum;

  assign in_stall  = (state_r != bpa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign free_off  = in_item.free_address - bpa_pkg::MAP_BASE;
  assign free_page = free_off[31:bpa_pkg::FRAME_SHIFT];
  assign a_bit     = bpa_pkg::ffz32(map_q_r);
  assign a_page    = {word_idx_r, a_bit};
  assign a_word    = map_q_r | (32'd1 << a_bit);
  assign a_sum     = sum_q_r | (32'd1 << word_idx_r[4:0]);

  always_comb begin
    state_nxt       = state_r;
    grp_idx_nxt     = grp_idx_r;
    word_idx_nxt    = word_idx_r;
    bit_nxt         = bit_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    sweep_reply_nxt = sweep_reply_r;
    grp_full_nxt    = grp_full_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;
    map_we          = 1'b0;
    map_waddr       = word_idx_r;
    map_wdata       = '0;
    sum_we          = 1'b0;
    sum_waddr       = grp_idx_r;
    sum_wdata       = '0;

    unique case (state_r)
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          res_nxt.page_address = '0;
          res_nxt.status       = bpa_pkg::ST_DONE;
          unique case (in_item.opcode)
            bpa_pkg::OP_ALLOC: state_nxt = bpa_pkg::S_A_GRP;
            bpa_pkg::OP_FREE: begin
              if (in_item.free_address < bpa_pkg::MAP_BASE ||
                  32'(free_page) >= bpa_pkg::NUM_PAGES) begin
                res_nxt.status = bpa_pkg::ST_IGNORED;
                state_nxt      = bpa_pkg::S_RESP;
              end else begin
                word_idx_nxt = free_page[PAGE_W-1:5];
                grp_idx_nxt  = free_page[PAGE_W-1:10];
                bit_nxt      = free_page[4:0];
                state_nxt    = bpa_pkg::S_F_WORD;
              end
            end
            bpa_pkg::OP_INIT: begin
              grp_full_nxt    = bpa_pkg::reset_grp();
              sweep_cnt_nxt   = '0;
              sweep_reply_nxt = 1'b1;
              state_nxt       = bpa_pkg::S_SWEEP;
            end
            bpa_pkg::OP_NOP: state_nxt = bpa_pkg::S_RESP;
          endcase
        end
      end

      // lowest group with a non-full word
      bpa_pkg::S_A_GRP: begin
        if (&grp_full_r) begin
          res_nxt.status = bpa_pkg::ST_OOM;
          state_nxt      = bpa_pkg::S_RESP;
        end else begin
          grp_idx_nxt = bpa_pkg::ffz_grp(grp_full_r);
          state_nxt   = bpa_pkg::S_A_SUM;
        end
      end

      // lowest non-full word in that group
      bpa_pkg::S_A_SUM: begin
        word_idx_nxt = {grp_idx_r, bpa_pkg::ffz32(sum_q_r)};
        state_nxt    = bpa_pkg::S_A_WORD;
      end

      // lowest free page in that word; padding pages beyond the table mean full
      bpa_pkg::S_A_WORD: begin
        if (32'(a_page) >= bpa_pkg::NUM_PAGES) begin
          res_nxt.status = bpa_pkg::ST_OOM;
        end else begin
          map_we    = 1'b1;
          map_wdata = a_word;
          if (&a_word) begin
            sum_we    = 1'b1;
            sum_wdata = a_sum;
            if (&a_sum) grp_full_nxt[grp_idx_r] = 1'b1;
          end
          res_nxt.page_address = bpa_pkg::MAP_BASE + (32'(a_page) << bpa_pkg::FRAME_SHIFT);
        end
        state_nxt = bpa_pkg::S_RESP;
      end

      // clear the page bit; the word can no longer be full
      bpa_pkg::S_F_WORD: begin
        map_we                  = 1'b1;
        map_wdata               = map_q_r & ~(32'd1 << bit_r);
        sum_we                  = 1'b1;
        sum_wdata               = sum_q_r & ~(32'd1 << word_idx_r[4:0]);
        grp_full_nxt[grp_idx_r] = 1'b0;
        state_nxt               = bpa_pkg::S_RESP;
      end

      bpa_pkg::S_SWEEP: begin
        map_we    = 1'b1;
        map_waddr = sweep_cnt_r;
        map_wdata = bpa_pkg::reset_word(sweep_cnt_r);
        if (32'(sweep_cnt_r) < GROUPS) begin
          sum_we    = 1'b1;
          sum_waddr = sweep_cnt_r[GRP_W-1:0];
          sum_wdata = bpa_pkg::reset_sum(sweep_cnt_r[GRP_W-1:0]);
        end
        sweep_cnt_nxt = sweep_cnt_r + WORD_W'(1);
        if (sweep_cnt_r == WORD_W'(bpa_pkg::MAP_DEPTH - 1)) begin
          state_nxt = sweep_reply_r ? bpa_pkg::S_RESP : bpa_pkg::S_IDLE;
        end
      end

      bpa_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = bpa_pkg::S_IDLE;
        end
      end

      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bpa_pkg::S_SWEEP;
      sweep_cnt_r   <= '0;
      sweep_reply_r <= 1'b0;
      grp_full_r    <= bpa_pkg::reset_grp();
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      grp_full_r    <= grp_full_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_idx_r  <= grp_idx_nxt;
    word_idx_r <= word_idx_nxt;
    bit_r      <= bit_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  // read addresses follow the next index so data lines up with the next state
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q_r <= map_mem[word_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_q_r <= sum_mem[grp_idx_nxt];
  end

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                   "item accepted but block still ready")
  `BPA_ASSERT_NOW(a_sum_not_full, state_r == bpa_pkg::S_A_SUM, sum_q_r != '1,
                  "group flagged free but summary full")
  `BPA_ASSERT_NOW(a_word_not_full, state_r == bpa_pkg::S_A_WORD, map_q_r != '1,
                  "summary says free but map word full")
  `BPA_ASSERT_NOW(a_page_aligned, out_valid, out_item.page_address[11:0] == 12'd0,
                  "page address not aligned")
  `BPA_ASSERT_NOW(a_addr_only_done, out_valid && out_item.page_address != 32'd0,
                  out_item.status == bpa_pkg::ST_DONE, "address returned with error status")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the bitmap first-fit page allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Shadow page map and the queue of grants still owed by the block.
  // Words below scan_word are known to be full, which keeps the
  // lowest-free search cheap.
  // ---------------------------------------------------------------------------
  class page_ledger;
    logic [31:0]        used_words [bpa_pkg::MAP_WORDS];
    int unsigned        scan_word;
    bpa_pkg::out_item_t pending_grants [$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      clear_map();
    endfunction

    function void clear_map();
      for (int w = 0; w < bpa_pkg::MAP_WORDS; w++) used_words[w] = '0;
      for (int p = 0; p < bpa_pkg::RES_LIMIT; p++) used_words[p >> 5][p & 31] = 1'b1;
      scan_word = 0;
    endfunction

    function bit take_lowest(output logic [31:0] pg);
      pg = '0;
      for (int unsigned w = scan_word; w < bpa_pkg::MAP_WORDS; w++) begin
        if (~used_words[w] != 32'd0) begin
          for (int b = 0; b < 32; b++) begin
            if (!used_words[w][b]) begin
              if (w * 32 + b >= bpa_pkg::NUM_PAGES) return 1'b0;
              used_words[w][b] = 1'b1;
              pg = 32'(w * 32 + b);
              scan_word = w;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Works out the grant for one accepted request and queues it.
    function void note_request(bpa_pkg::in_item_t req);
      bpa_pkg::out_item_t exp;
      logic [31:0]        pg;
      exp.page_address = '0;
      exp.status       = bpa_pkg::ST_DONE;
      case (req.opcode)
        bpa_pkg::OP_ALLOC: begin
          if (take_lowest(pg))
            exp.page_address = bpa_pkg::MAP_BASE + (pg << bpa_pkg::FRAME_SHIFT);
          else exp.status = bpa_pkg::ST_OOM;
        end
        bpa_pkg::OP_FREE: begin
          if (req.free_address < bpa_pkg::MAP_BASE) begin
            exp.status = bpa_pkg::ST_IGNORED;
          end else begin
            pg = (req.free_address - bpa_pkg::MAP_BASE) >> bpa_pkg::FRAME_SHIFT;
            if (pg >= bpa_pkg::NUM_PAGES) begin
              exp.status = bpa_pkg::ST_IGNORED;
            end else begin
              used_words[pg >> 5][pg[4:0]] = 1'b0;
              if ((pg >> 5) < scan_word) scan_word = pg >> 5;
            end
          end
        end
        bpa_pkg::OP_INIT: clear_map();
        default: ;
      endcase
      pending_grants.push_back(exp);
    endfunction

    function void check_grant(bpa_pkg::out_item_t got);
      bpa_pkg::out_item_t exp;
      if (pending_grants.size() == 0) begin
        $error("unexpected result: page_address %h status %0d", got.page_address, got.status);
        mismatches++;
        return;
      end
      exp = pending_grants.pop_front();
      if (got.page_address !== exp.page_address) begin
        $error("page_address: expected %h, got %h", exp.page_address, got.page_address);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  bpa_pkg::in_item_t  in_item   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  bpa_pkg::out_item_t out_item;

  page_ledger ledger = new();

  // quiet stretches: no gaps from the sender / no stalls from the receiver
  bit          tx_calm  = 1'b0;
  bit          rx_calm  = 1'b0;
  // long receiver hold-off, handed to the result process
  bit          hold_go  = 1'b0;
  int unsigned hold_len = 0;

  always #10 clk = ~clk;

  bitmap_page_allocator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // ---------------------------------------------------------------------------
  // Random shaping
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bpa_pkg::opcode_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 46) return bpa_pkg::OP_ALLOC;
    if (r < 92) return bpa_pkg::OP_FREE;
    if (r < 98) return bpa_pkg::OP_NOP;
    return bpa_pkg::OP_INIT;
  endfunction

  // Frees mostly land on the live region just above the reserved pages
  // (allocated, free and reserved pages alike); the rest probe the edges:
  // anywhere in the table, below the base, just past the table, any value.
  function automatic logic [31:0] pick_free_address();
    int unsigned r;
    int unsigned page;
    r = $urandom_range(0, 99);
    if (r < 65) page = $urandom_range(400, 1200);
    else if (r < 75) page = $urandom_range(0, bpa_pkg::NUM_PAGES - 1);
    else if (r < 82) return 32'($urandom_range(0, bpa_pkg::MAP_BASE - 1));
    else if (r < 88) page = bpa_pkg::NUM_PAGES + $urandom_range(0, 3);
    else return $urandom();
    return bpa_pkg::MAP_BASE + (32'(page) << bpa_pkg::FRAME_SHIFT)
           + 32'($urandom_range(0, 4095));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one item, hold it until taken, note it, then maybe idle.
  // Called at a rising edge, so every drive below is at the edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input bpa_pkg::opcode_t op, input logic [31:0] addr);
    bpa_pkg::in_item_t it;
    int unsigned       gap;
    it.opcode       = op;
    it.free_address = addr;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ledger.note_request(it);
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result, then choose the next stall.
  // A requested hold-off is counted down here, independent of the sender.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned gap;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) ledger.check_grant(out_item);
      if (hold_go) begin
        stall_left = hold_len;
        hold_go    = 1'b0;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        gap = pick_gap();
        out_stall <= (gap != 0);
        if (gap != 0) stall_left = gap - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bpa_pkg::opcode_t op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first fit above the reserved pages, offset bits dropped on
    // free, freeing an already free page, frees below the base and past the
    // table, the unused opcode, and re-init after reserved pages were freed.
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_item(bpa_pkg::OP_FREE,
              bpa_pkg::MAP_BASE + (32'd512 << bpa_pkg::FRAME_SHIFT) + 32'hFFF);
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE + (32'd600 << bpa_pkg::FRAME_SHIFT));
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE - 32'd1);
    send_item(bpa_pkg::OP_FREE,  32'h0000_0000);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE);
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE
              + (32'(bpa_pkg::NUM_PAGES - 1) << bpa_pkg::FRAME_SHIFT) + 32'hFFF);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE
              + (32'(bpa_pkg::NUM_PAGES) << bpa_pkg::FRAME_SHIFT));
    send_item(bpa_pkg::OP_FREE,  32'hFFFF_FFFF);
    send_item(bpa_pkg::OP_NOP,   32'hFFFF_FFFF);
    send_item(bpa_pkg::OP_NOP,   32'h0000_0000);
    send_item(bpa_pkg::OP_INIT,  32'hFFFF_FFFF);
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE + 32'hFFF);
    send_item(bpa_pkg::OP_FREE,  bpa_pkg::MAP_BASE + (32'd31 << bpa_pkg::FRAME_SHIFT));
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(bpa_pkg::OP_ALLOC, 32'h0000_0000);

    // Churn across the whole table: scattered frees open holes anywhere,
    // allocs must refill the lowest hole first.
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 1) != 0)
        send_item(bpa_pkg::OP_FREE, bpa_pkg::MAP_BASE
                  + (32'($urandom_range(0, bpa_pkg::NUM_PAGES - 1)) << bpa_pkg::FRAME_SHIFT)
                  + 32'($urandom_range(0, 4095)));
      else
        send_item(bpa_pkg::OP_ALLOC, $urandom());
    end

    // Main random mix from a fresh map.
    send_item(bpa_pkg::OP_INIT, $urandom());
    for (int i = 0; i < 1300; i++) begin
      if (i % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      // back-pressure: receiver holds off while items keep coming
      if (i == 650) begin
        hold_len = $urandom_range(250, 400);
        hold_go  = 1'b1;
        tx_calm  = 1'b1;
      end
      op = pick_op();
      send_item(op, (op == bpa_pkg::OP_FREE) ? pick_free_address() : $urandom());
    end

    // Drain, then watch for anything stray.
    in_valid <= 1'b0;
    rx_calm = 1'b1;
    while (ledger.pending_grants.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin : watchdog
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
